>>> rtl/core/edf_task_scheduler_top_macros.svh
// assertion macros for the edf scheduler rtl
// expects clk and arst_n in the scope of the module that uses them
`ifndef EDF_TASK_SCHEDULER_TOP_MACROS_SVH
`define EDF_TASK_SCHEDULER_TOP_MACROS_SVH

// consequent checked in the same cycle
`define EDF_ASSERT_SAME(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define EDF_ASSERT_NEXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/edf_pkg.sv
// shared types and codes for the edf scheduler
// no dependencies
package edf_pkg;

	localparam int ID_W       = 4;
	localparam int OUT_TIME_W = 32;
	localparam int REL_W      = 5;

	typedef enum logic [2:0] {
		OP_CREATE       = 3'd0,
		OP_TERMINATE    = 3'd1,
		OP_SLEEP        = 3'd2,
		OP_BLOCK        = 3'd3,
		OP_RELEASE      = 3'd4,
		OP_SET_DEADLINE = 3'd5,
		OP_TICK         = 3'd6,
		OP_SET_COUNTER  = 3'd7
	} opcode_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		Q_READY   = 2'd0,
		Q_SLEEP   = 2'd1,
		Q_BLOCKED = 2'd2
	} queue_t;

	typedef enum logic [1:0] {
		RA_IDX  = 2'd0,
		RA_IDX1 = 2'd1,
		RA_ZERO = 2'd2
	} rd_sel_t;

	typedef enum logic [2:0] {
		IDX_HOLD = 3'd0,
		IDX_ZERO = 3'd1,
		IDX_TOP  = 3'd2,
		IDX_INC  = 3'd3,
		IDX_DEC  = 3'd4
	} idx_op_t;

	typedef enum logic [1:0] {
		WR_NONE    = 2'd0,
		WR_DATA_DN = 2'd1,
		WR_DATA_UP = 2'd2,
		WR_ENT_UP  = 2'd3
	} wr_mode_t;

	typedef enum logic [1:0] {
		CNT_HOLD = 2'd0,
		CNT_INC  = 2'd1,
		CNT_DEC  = 2'd2
	} cnt_op_t;

	typedef enum logic [2:0] {
		ENT_HOLD    = 3'd0,
		ENT_INPUT   = 3'd1,
		ENT_HEAD    = 3'd2,
		ENT_BLOCKED = 3'd3,
		ENT_SLEEPER = 3'd4
	} ent_src_t;

	typedef struct packed {
		logic     latch;
		queue_t   q;
		rd_sel_t  rd_sel;
		idx_op_t  idx_op;
		wr_mode_t wr_mode;
		cnt_op_t  cnt_op;
		ent_src_t ent_src;
		logic     stat_set;
		status_t  stat_val;
		logic     tick_inc;
		logic     tick_load;
		logic     rel_inc;
		logic     out_load;
	} cmd_t;

	typedef struct packed {
		opcode_t op;
		logic    full;
		logic    q_empty;
		logic    idx_neg;
		logic    idx_next_lt_cnt;
		logic    key_ge;
		logic    id_match;
		logic    due;
	} sts_t;

endpackage

>>> rtl/core/edf_ram.sv
// generic single write port ram with registered read
// no dependencies
module edf_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> rtl/core/edf_dpath.sv
// datapath: three sorted queues in ram, counts, tick counter, result registers
// depends on edf_pkg and edf_ram
module edf_dpath import edf_pkg::*; #(
	parameter int MAX_TASKS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [2:0]            opcode,
	input  logic [ID_W-1:0]       task_number,
	input  logic [31:0]           operand_value,
	input  cmd_t                  cmd,
	output sts_t                  sts,
	output logic [ID_W-1:0]       running_task,
	output logic                  running_valid,
	output logic [OUT_TIME_W-1:0] running_deadline,
	output logic [1:0]            status,
	output logic [REL_W-1:0]      released_count,
	output logic [OUT_TIME_W-1:0] tick_now,
	output logic                  done
);

	localparam int AW = $clog2(MAX_TASKS);
	localparam int CW = $clog2(MAX_TASKS + 1);
	localparam int RW = ID_W + TIME_BITS;
	localparam int SW = ID_W + 2 * TIME_BITS;

	opcode_t              op_q;
	logic [ID_W-1:0]      tn_q;
	logic [TIME_BITS-1:0] v_q;
	logic [TIME_BITS-1:0] tick_q;
	logic [CW-1:0]        cnt_r_q, cnt_s_q, cnt_b_q;
	logic [CW-1:0]        idx_q;
	logic [CW-1:0]        rel_q;
	logic [ID_W-1:0]      ent_id_q;
	logic [TIME_BITS-1:0] ent_key_q, ent_aux_q;
	status_t              status_q;
	logic                 done_q;

	logic [CW-1:0]        cnt_sel, idx1;
	logic [CW+1:0]        total;
	logic [AW-1:0]        raddr, waddr;
	logic [RW-1:0]        r_rd, b_rd;
	logic [SW-1:0]        s_rd, wdata;
	logic [ID_W-1:0]      rd_id;
	logic [TIME_BITS-1:0] rd_key, rd_aux;
	logic                 we_any;

	always_comb begin
		case (cmd.q)
			Q_SLEEP:   cnt_sel = cnt_s_q;
			Q_BLOCKED: cnt_sel = cnt_b_q;
			default:   cnt_sel = cnt_r_q;
		endcase
	end

	assign idx1  = idx_q + CW'(1);
	assign total = (CW+2)'(cnt_r_q) + (CW+2)'(cnt_s_q) + (CW+2)'(cnt_b_q);

	always_comb begin
		case (cmd.rd_sel)
			RA_IDX:  raddr = idx_q[AW-1:0];
			RA_IDX1: raddr = idx1[AW-1:0];
			default: raddr = '0;
		endcase
	end

	always_comb begin
		case (cmd.q)
			Q_SLEEP: begin
				rd_id  = s_rd[ID_W-1:0];
				rd_key = s_rd[RW-1:ID_W];
			end
			Q_BLOCKED: begin
				rd_id  = b_rd[ID_W-1:0];
				rd_key = b_rd[RW-1:ID_W];
			end
			default: begin
				rd_id  = r_rd[ID_W-1:0];
				rd_key = r_rd[RW-1:ID_W];
			end
		endcase
	end
	assign rd_aux = s_rd[SW-1:RW];

	// shift down writes at idx, everything else lands one above idx
	assign waddr  = (cmd.wr_mode == WR_DATA_DN) ? idx_q[AW-1:0] : idx1[AW-1:0];
	assign wdata  = (cmd.wr_mode == WR_ENT_UP) ? {ent_aux_q, ent_key_q, ent_id_q}
		: {rd_aux, rd_key, rd_id};
	assign we_any = (cmd.wr_mode != WR_NONE);

	edf_ram #(.WIDTH(RW), .DEPTH(MAX_TASKS)) u_ready_ram (
		.clk   (clk),
		.we    (we_any && cmd.q == Q_READY),
		.waddr (waddr),
		.wdata (wdata[RW-1:0]),
		.raddr (raddr),
		.rdata (r_rd)
	);

	edf_ram #(.WIDTH(SW), .DEPTH(MAX_TASKS)) u_sleep_ram (
		.clk   (clk),
		.we    (we_any && cmd.q == Q_SLEEP),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (s_rd)
	);

	edf_ram #(.WIDTH(RW), .DEPTH(MAX_TASKS)) u_blocked_ram (
		.clk   (clk),
		.we    (we_any && cmd.q == Q_BLOCKED),
		.waddr (waddr),
		.wdata (wdata[RW-1:0]),
		.raddr (raddr),
		.rdata (b_rd)
	);

	always_comb begin
		sts.op              = op_q;
		sts.full            = total >= (CW+2)'(MAX_TASKS);
		sts.q_empty         = (cnt_sel == '0);
		sts.idx_neg         = &idx_q;
		sts.idx_next_lt_cnt = idx1 < cnt_sel;
		sts.key_ge          = rd_key >= ent_key_q;
		sts.id_match        = rd_id == tn_q;
		sts.due             = rd_key <= tick_q;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_r_q <= '0;
			cnt_s_q <= '0;
			cnt_b_q <= '0;
			tick_q  <= '0;
			idx_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.out_load;
			case (cmd.idx_op)
				IDX_ZERO: idx_q <= '0;
				IDX_TOP:  idx_q <= cnt_sel - CW'(1);
				IDX_INC:  idx_q <= idx1;
				IDX_DEC:  idx_q <= idx_q - CW'(1);
				default:  idx_q <= idx_q;
			endcase
			if (cmd.cnt_op != CNT_HOLD) begin
				case (cmd.q)
					Q_SLEEP:   cnt_s_q <= (cmd.cnt_op == CNT_INC) ? cnt_s_q + CW'(1)
						: cnt_s_q - CW'(1);
					Q_BLOCKED: cnt_b_q <= (cmd.cnt_op == CNT_INC) ? cnt_b_q + CW'(1)
						: cnt_b_q - CW'(1);
					default:   cnt_r_q <= (cmd.cnt_op == CNT_INC) ? cnt_r_q + CW'(1)
						: cnt_r_q - CW'(1);
				endcase
			end
			if (cmd.tick_inc) begin
				tick_q <= tick_q + TIME_BITS'(1);
			end else if (cmd.tick_load && v_q > tick_q) begin
				tick_q <= v_q;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (cmd.latch) begin
			op_q     <= opcode_t'(opcode);
			tn_q     <= task_number;
			v_q      <= TIME_BITS'(operand_value);
			status_q <= ST_OK;
			rel_q    <= '0;
		end
		if (cmd.stat_set) begin
			status_q <= cmd.stat_val;
		end
		if (cmd.rel_inc) begin
			rel_q <= rel_q + CW'(1);
		end
		case (cmd.ent_src)
			ENT_INPUT: begin
				ent_id_q  <= tn_q;
				ent_key_q <= v_q;
			end
			ENT_HEAD: begin
				ent_id_q  <= rd_id;
				ent_aux_q <= rd_key;
				case (op_q)
					OP_SLEEP: ent_key_q <= tick_q + v_q;
					OP_BLOCK: ent_key_q <= rd_key;
					default:  ent_key_q <= v_q;
				endcase
			end
			ENT_BLOCKED: begin
				ent_id_q  <= rd_id;
				ent_key_q <= rd_key;
			end
			ENT_SLEEPER: begin
				ent_id_q  <= rd_id;
				ent_key_q <= rd_aux;
			end
			default: ;
		endcase
		if (cmd.out_load) begin
			running_valid    <= (cnt_r_q != '0);
			running_task     <= (cnt_r_q != '0) ? rd_id : '0;
			running_deadline <= (cnt_r_q != '0) ? OUT_TIME_W'(rd_key) : '0;
			status           <= status_q;
			released_count   <= REL_W'(rel_q);
			tick_now         <= OUT_TIME_W'(tick_q);
		end
	end

	assign done = done_q;

endmodule

>>> rtl/core/edf_ctrl.sv
// controller: sequences queue scans, shifts and inserts for each command
// depends on edf_pkg
module edf_ctrl import edf_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  sts_t sts,
	output logic busy,
	output cmd_t cmd
);

	typedef enum logic [13:0] {
		S_IDLE    = 14'b00000000000001,
		S_DISP    = 14'b00000000000010,
		S_HEAD    = 14'b00000000000100,
		S_FD_RD   = 14'b00000000001000,
		S_FD_CHK  = 14'b00000000010000,
		S_TK_RD   = 14'b00000000100000,
		S_TK_CHK  = 14'b00000001000000,
		S_DR_RD   = 14'b00000010000000,
		S_DR_WR   = 14'b00000100000000,
		S_PT_INIT = 14'b00001000000000,
		S_PT_RD   = 14'b00010000000000,
		S_PT_WR   = 14'b00100000000000,
		S_OUT_RD  = 14'b01000000000000,
		S_OUT_WR  = 14'b10000000000000
	} state_t;

	state_t state_q, state_d;
	logic   phase_q, phase_d;
	queue_t drop_q_sel, put_q_sel, tick_q_sel;
	state_t after_put;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			phase_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
		end
	end

	assign tick_q_sel = phase_q ? Q_BLOCKED : Q_SLEEP;
	assign after_put  = (sts.op == OP_TICK) ? S_TK_RD : S_OUT_RD;

	always_comb begin
		case (sts.op)
			OP_RELEASE: drop_q_sel = Q_BLOCKED;
			OP_TICK:    drop_q_sel = tick_q_sel;
			default:    drop_q_sel = Q_READY;
		endcase
		case (sts.op)
			OP_SLEEP: put_q_sel = Q_SLEEP;
			OP_BLOCK: put_q_sel = Q_BLOCKED;
			default:  put_q_sel = Q_READY;
		endcase
	end

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		phase_d = phase_q;
		unique case (state_q)
			S_IDLE: begin
				if (start) begin
					cmd.latch = 1'b1;
					state_d   = S_DISP;
				end
			end
			S_DISP: begin
				unique case (sts.op)
					OP_CREATE: begin
						if (sts.full) begin
							cmd.stat_set = 1'b1;
							cmd.stat_val = ST_FULL;
							state_d      = S_OUT_RD;
						end else begin
							cmd.ent_src = ENT_INPUT;
							state_d     = S_PT_INIT;
						end
					end
					OP_TERMINATE, OP_SLEEP, OP_BLOCK, OP_SET_DEADLINE: begin
						cmd.q = Q_READY;
						if (sts.q_empty) begin
							cmd.stat_set = 1'b1;
							cmd.stat_val = ST_EMPTY;
							state_d      = S_OUT_RD;
						end else begin
							cmd.rd_sel = RA_ZERO;
							cmd.idx_op = IDX_ZERO;
							state_d    = S_HEAD;
						end
					end
					OP_RELEASE: begin
						cmd.q = Q_BLOCKED;
						if (sts.q_empty) begin
							cmd.stat_set = 1'b1;
							cmd.stat_val = ST_EMPTY;
							state_d      = S_OUT_RD;
						end else begin
							cmd.idx_op = IDX_ZERO;
							state_d    = S_FD_RD;
						end
					end
					OP_TICK: begin
						cmd.tick_inc = 1'b1;
						phase_d      = 1'b0;
						state_d      = S_TK_RD;
					end
					OP_SET_COUNTER: begin
						cmd.tick_load = 1'b1;
						state_d       = S_OUT_RD;
					end
				endcase
			end
			S_HEAD: begin
				cmd.q       = Q_READY;
				cmd.ent_src = ENT_HEAD;
				state_d     = S_DR_RD;
			end
			S_FD_RD: begin
				cmd.q      = Q_BLOCKED;
				cmd.rd_sel = RA_IDX;
				state_d    = S_FD_CHK;
			end
			S_FD_CHK: begin
				cmd.q = Q_BLOCKED;
				if (sts.id_match) begin
					cmd.ent_src = ENT_BLOCKED;
					state_d     = S_DR_RD;
				end else if (sts.idx_next_lt_cnt) begin
					cmd.idx_op = IDX_INC;
					state_d    = S_FD_RD;
				end else begin
					cmd.stat_set = 1'b1;
					cmd.stat_val = ST_EMPTY;
					state_d      = S_OUT_RD;
				end
			end
			S_TK_RD: begin
				cmd.q = tick_q_sel;
				if (sts.q_empty) begin
					if (!phase_q) begin
						phase_d = 1'b1;
					end else begin
						state_d = S_OUT_RD;
					end
				end else begin
					cmd.rd_sel = RA_ZERO;
					cmd.idx_op = IDX_ZERO;
					state_d    = S_TK_CHK;
				end
			end
			S_TK_CHK: begin
				cmd.q = tick_q_sel;
				if (sts.due) begin
					cmd.ent_src = phase_q ? ENT_BLOCKED : ENT_SLEEPER;
					cmd.rel_inc = 1'b1;
					state_d     = S_DR_RD;
				end else if (!phase_q) begin
					phase_d = 1'b1;
					state_d = S_TK_RD;
				end else begin
					state_d = S_OUT_RD;
				end
			end
			S_DR_RD: begin
				cmd.q = drop_q_sel;
				if (sts.idx_next_lt_cnt) begin
					cmd.rd_sel = RA_IDX1;
					state_d    = S_DR_WR;
				end else begin
					cmd.cnt_op = CNT_DEC;
					state_d    = (sts.op == OP_TERMINATE) ? S_OUT_RD : S_PT_INIT;
				end
			end
			S_DR_WR: begin
				cmd.q       = drop_q_sel;
				cmd.wr_mode = WR_DATA_DN;
				cmd.idx_op  = IDX_INC;
				state_d     = S_DR_RD;
			end
			S_PT_INIT: begin
				cmd.q      = put_q_sel;
				cmd.idx_op = IDX_TOP;
				state_d    = S_PT_RD;
			end
			S_PT_RD: begin
				cmd.q = put_q_sel;
				if (sts.idx_neg) begin
					cmd.wr_mode = WR_ENT_UP;
					cmd.cnt_op  = CNT_INC;
					state_d     = after_put;
				end else begin
					cmd.rd_sel = RA_IDX;
					state_d    = S_PT_WR;
				end
			end
			S_PT_WR: begin
				cmd.q = put_q_sel;
				if (sts.key_ge) begin
					cmd.wr_mode = WR_DATA_UP;
					cmd.idx_op  = IDX_DEC;
					state_d     = S_PT_RD;
				end else begin
					cmd.wr_mode = WR_ENT_UP;
					cmd.cnt_op  = CNT_INC;
					state_d     = after_put;
				end
			end
			S_OUT_RD: begin
				cmd.q      = Q_READY;
				cmd.rd_sel = RA_ZERO;
				state_d    = S_OUT_WR;
			end
			S_OUT_WR: begin
				cmd.q        = Q_READY;
				cmd.out_load = 1'b1;
				state_d      = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	assign busy = (state_q != S_IDLE);

endmodule

>>> rtl/core/edf_task_scheduler_top.sv
// top level of the edf task scheduler
// depends on edf_pkg, edf_ctrl, edf_dpath, edf_ram and the assertion macro header
`include "edf_task_scheduler_top_macros.svh"

// Earliest-deadline-first scheduler with ready, sleeping and blocked queues, each kept
// sorted in its own ram, plus a tick counter. A command word is taken when start is high
// and busy is low; busy then stays high until the result word appears, and done is high
// for exactly one cycle with the result, in the first cycle with busy low, so a new
// command may be taken at the edge that ends it. The receiver cannot stall: the result
// word must be captured in that cycle. Commands are handled one at a time. Every queue
// move walks the ram one entry at a time, reading it and then writing it. Set counter
// and any error or full case go straight to the result; a terminate shifts the ready
// entries behind the head; a create shifts the entries above its slot; a release or set
// deadline also scans or shifts its source queue; a tick moves each due task in turn.
// Status: 0 ok, 1 all queues together full, 2 ready or blocked queue empty, or task
// not found.
module edf_task_scheduler_top import edf_pkg::*; #(
	parameter int MAX_TASKS = 16,
	parameter int TIME_BITS = 32
) (
	input  logic                  clk,
	input  logic                  arst_n,
	// command word
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            opcode,
	input  logic [ID_W-1:0]       task_number,
	input  logic [31:0]           operand_value,
	// result word, valid while done is high
	output logic                  done,
	output logic [ID_W-1:0]       running_task,
	output logic                  running_valid,
	output logic [OUT_TIME_W-1:0] running_deadline,
	output logic [1:0]            status,
	output logic [REL_W-1:0]      released_count,
	output logic [OUT_TIME_W-1:0] tick_now
);

	cmd_t cmd;
	sts_t sts;

	// sequencer
	edf_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.sts    (sts),
		.busy   (busy),
		.cmd    (cmd)
	);

	// queues, counter and result registers
	edf_dpath #(
		.MAX_TASKS (MAX_TASKS),
		.TIME_BITS (TIME_BITS)
	) u_dpath (
		.clk              (clk),
		.arst_n           (arst_n),
		.opcode           (opcode),
		.task_number      (task_number),
		.operand_value    (operand_value),
		.cmd              (cmd),
		.sts              (sts),
		.running_task     (running_task),
		.running_valid    (running_valid),
		.running_deadline (running_deadline),
		.status           (status),
		.released_count   (released_count),
		.tick_now         (tick_now),
		.done             (done)
	);

	// an accepted word always starts a sequence
	`EDF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted word did not raise busy")
	// the result comes out as the sequencer returns to idle
	`EDF_ASSERT_SAME(a_done_idle, done, !busy, "result issued while still busy")
	// an empty ready queue reports zeros
	`EDF_ASSERT_SAME(a_empty_zero, done && !running_valid, running_task == '0 && running_deadline == '0, "empty ready queue gave nonzero head")
	// only ticks release tasks, and ticks always report ok
	`EDF_ASSERT_SAME(a_release_ok, done && released_count != '0, status == ST_OK, "released tasks with error status")

endmodule
